// ----- sv/versatile_interface_adapter_defines.svh -----
// Assertion macros shared by the interface adapter checker.
// No dependencies; include by bare file name.
`ifndef VERSATILE_INTERFACE_ADAPTER_DEFINES_SVH
`define VERSATILE_INTERFACE_ADAPTER_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define VIA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("via: same-cycle property violated");

// Next-cycle implication, ignored while reset is high.
`define VIA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("via: next-cycle property violated");

// Next-cycle implication that also holds across reset.
`define VIA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("via: reset property violated");

`endif

// ----- sv/via_pkg.sv -----
`timescale 1ns / 1ps
// Types, codes and helpers for the versatile interface adapter.
// No dependencies; imported by the top level and its checker.
package via_pkg;

   typedef enum logic [2:0] {
      ACT_TICK    = 3'd0,
      ACT_READ    = 3'd1,
      ACT_WRITE   = 3'd2,
      ACT_DRIVE_A = 3'd3,
      ACT_DRIVE_B = 3'd4
   } action_type;

   // Register map, standard 6522 order
   localparam logic [3:0] REG_ORB    = 4'd0;
   localparam logic [3:0] REG_ORA    = 4'd1;
   localparam logic [3:0] REG_DDRB   = 4'd2;
   localparam logic [3:0] REG_DDRA   = 4'd3;
   localparam logic [3:0] REG_T1CL   = 4'd4;
   localparam logic [3:0] REG_T1CH   = 4'd5;
   localparam logic [3:0] REG_T1LL   = 4'd6;
   localparam logic [3:0] REG_T1LH   = 4'd7;
   localparam logic [3:0] REG_T2CL   = 4'd8;
   localparam logic [3:0] REG_T2CH   = 4'd9;
   localparam logic [3:0] REG_SR     = 4'd10;
   localparam logic [3:0] REG_ACR    = 4'd11;
   localparam logic [3:0] REG_PCR    = 4'd12;
   localparam logic [3:0] REG_IFR    = 4'd13;
   localparam logic [3:0] REG_IER    = 4'd14;
   localparam logic [3:0] REG_ORA_NH = 4'd15;

   // Interrupt flag bit positions
   localparam int FLAG_CA2 = 0;
   localparam int FLAG_CA1 = 1;
   localparam int FLAG_SR  = 2;
   localparam int FLAG_CB2 = 3;
   localparam int FLAG_CB1 = 4;
   localparam int FLAG_T2  = 5;
   localparam int FLAG_T1  = 6;

   // ACR and PCR control bits
   localparam int ACR_T2_PULSES = 5;
   localparam int ACR_T1_FREE   = 6;
   localparam int PCR_CA1_POS   = 0;
   localparam int PCR_CB1_POS   = 4;

   // CA2/CB2 manual output modes
   localparam logic [2:0] CTL2_MANUAL_LOW  = 3'b110;
   localparam logic [2:0] CTL2_MANUAL_HIGH = 3'b111;

   localparam logic signed [17:0] ONE_SHOT_RELOAD = 18'sh0FFFF;

   typedef struct packed {
      logic [2:0] action;
      logic [3:0] reg_index;
      logic [7:0] data;
      logic [7:0] tick_cycles;
      logic       ca1_level;
      logic       cb1_level;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq;
      logic [7:0] port_a_pins;
      logic [7:0] port_b_pins;
      logic       ca2_out;
      logic       cb2_out;
   } rsp_type;

   // Saturate a 19-bit signed value to the 18-bit counter range
   function automatic logic signed [17:0] sat18(input logic signed [18:0] v);
      logic signed [17:0] r;
      if (v[18] != v[17]) begin
         r = v[18] ? 18'sh20000 : 18'sh1FFFF;
      end else begin
         r = v[17:0];
      end
      return r;
   endfunction

endpackage

// ----- sv/versatile_interface_adapter.sv -----
`timescale 1ns / 1ps
// Versatile interface adapter: 6522-style ports, timers, edge flags and IRQ.
// Depends on via_pkg.
//
// Usage:
//   req_valid/req_stall/req_payload carry one transaction: a timer tick,
//   a register read or write, or an external drive of port A or B pins.
//   rsp_valid/rsp_stall/rsp_payload return one result per transaction:
//   read data, irq level, both pin bytes and the CA2/CB2 output levels.
//   A transaction is taken at an edge where valid is high and stall low.
// Pipeline:
//   A transaction is registered on acceptance, executed from the request
//   register against the register state once the result register is free
//   or draining, and its result registered into the result register. One
//   transaction per cycle is sustained while the result is not stalled;
//   the state update is a single pass of one 19-bit subtract, add and
//   saturate per timer, which sets the cycle time.
// Reset:
//   Synchronous, active high. All state registers go to their 6522 defaults
//   (pins and input latches to all ones, everything else zero) and both
//   channels empty; the payload registers are not reset.
// Stalls:
//   While the result is stalled it holds; the request side stalls only
//   when an executed transaction would have nowhere to go.
module versatile_interface_adapter
   import via_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_req_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    adv;

   logic signed [17:0] t1_count_ff, t1_count_in;
   logic [15:0]        t1_reload_ff, t1_reload_in;
   logic signed [17:0] t2_count_ff, t2_count_in;
   logic [7:0]         t2_low_ff, t2_low_in;
   logic               t1_fired_ff, t1_fired_in;
   logic               t2_fired_ff, t2_fired_in;
   logic               ca1_prev_ff, ca1_prev_in;
   logic               cb1_prev_ff, cb1_prev_in;
   logic               ca2_ff, ca2_in;
   logic               cb2_ff, cb2_in;
   logic [7:0]         dir_a_ff, dir_a_in;
   logic [7:0]         dir_b_ff, dir_b_in;
   logic [7:0]         out_a_ff, out_a_in;
   logic [7:0]         out_b_ff, out_b_in;
   logic [7:0]         pins_a_ff, pins_a_in;
   logic [7:0]         pins_b_ff, pins_b_in;
   logic [6:0]         ifr_ff, ifr_in;
   logic [6:0]         ier_ff, ier_in;
   logic [7:0]         acr_ff, acr_in;
   logic [7:0]         pcr_ff, pcr_in;
   logic [7:0]         sr_ff, sr_in;

   logic signed [18:0] t1_sub, t2_sub, t1_free_sum;
   logic signed [17:0] t1_dec, t2_dec;
   logic               t1_le0, t2_le0;
   logic [7:0]         in_b;
   logic [7:0]         read_val;
   logic [7:0]         rd_out;

   // Execute when the result register is free or being drained
   assign adv         = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && rsp_valid_ff && rsp_stall;
   assign s1_valid_in = req_stall ? s1_valid_ff : req_valid;
   assign rsp_valid_in = adv ? 1'b1 : (rsp_valid_ff && rsp_stall);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Port B input latch shows pins on input bits and ORB on output bits
   assign in_b = (pins_b_ff & ~dir_b_ff) | (out_b_ff & dir_b_ff);

   // Timer arithmetic
   always_comb begin
      t1_sub      = {t1_count_ff[17], t1_count_ff} - {11'd0, s1_req_ff.tick_cycles};
      t1_dec      = sat18(t1_sub);
      t1_le0      = t1_dec[17] || (t1_dec == 18'sd0);
      t1_free_sum = {t1_dec[17], t1_dec} + {3'd0, t1_reload_ff} + 19'sd2;
      t2_sub      = {t2_count_ff[17], t2_count_ff} - {11'd0, s1_req_ff.tick_cycles};
      t2_dec      = sat18(t2_sub);
      t2_le0      = t2_dec[17] || (t2_dec == 18'sd0);
   end

   // Register read mux, from state before this transaction
   always_comb begin
      case (s1_req_ff.reg_index)
         REG_ORB:  read_val = in_b;
         REG_ORA:  read_val = pins_a_ff;
         REG_DDRB: read_val = dir_b_ff;
         REG_DDRA: read_val = dir_a_ff;
         REG_T1CL: read_val = t1_count_ff[7:0];
         REG_T1CH: read_val = t1_count_ff[15:8];
         REG_T1LL: read_val = t1_reload_ff[7:0];
         REG_T1LH: read_val = t1_reload_ff[15:8];
         REG_T2CL: read_val = t2_count_ff[7:0];
         REG_T2CH: read_val = t2_count_ff[15:8];
         REG_SR:   read_val = sr_ff;
         REG_ACR:  read_val = acr_ff;
         REG_PCR:  read_val = pcr_ff;
         REG_IFR:  read_val = {|(ifr_ff & ier_ff), ifr_ff};
         REG_IER:  read_val = {1'b1, ier_ff};
         default:  read_val = pins_a_ff;
      endcase
   end

   // Next state
   always_comb begin
      t1_count_in  = t1_count_ff;
      t1_reload_in = t1_reload_ff;
      t2_count_in  = t2_count_ff;
      t2_low_in    = t2_low_ff;
      t1_fired_in  = t1_fired_ff;
      t2_fired_in  = t2_fired_ff;
      ca1_prev_in  = ca1_prev_ff;
      cb1_prev_in  = cb1_prev_ff;
      ca2_in       = ca2_ff;
      cb2_in       = cb2_ff;
      dir_a_in     = dir_a_ff;
      dir_b_in     = dir_b_ff;
      out_a_in     = out_a_ff;
      out_b_in     = out_b_ff;
      pins_a_in    = pins_a_ff;
      pins_b_in    = pins_b_ff;
      ifr_in       = ifr_ff;
      ier_in       = ier_ff;
      acr_in       = acr_ff;
      pcr_in       = pcr_ff;
      sr_in        = sr_ff;
      rd_out       = 8'd0;

      if (adv) begin
         case (s1_req_ff.action)
            ACT_TICK: begin
               t1_count_in = t1_dec;
               if (t1_le0) begin
                  if (acr_ff[ACR_T1_FREE]) begin
                     t1_count_in      = sat18(t1_free_sum);
                     ifr_in[FLAG_T1]  = 1'b1;
                  end else if (!t1_fired_ff) begin
                     t1_count_in      = t1_dec + ONE_SHOT_RELOAD;
                     t1_fired_in      = 1'b1;
                     ifr_in[FLAG_T1]  = 1'b1;
                  end else begin
                     t1_count_in      = {2'b00, t1_dec[15:0]};
                  end
               end
               if (!acr_ff[ACR_T2_PULSES]) begin
                  t2_count_in = t2_dec;
                  if (t2_le0 && !t2_fired_ff) begin
                     t2_count_in     = t2_dec + ONE_SHOT_RELOAD;
                     t2_fired_in     = 1'b1;
                     ifr_in[FLAG_T2] = 1'b1;
                  end
               end
               if (s1_req_ff.ca1_level != ca1_prev_ff) begin
                  if (pcr_ff[PCR_CA1_POS] == s1_req_ff.ca1_level) begin
                     ifr_in[FLAG_CA1] = 1'b1;
                  end
                  ca1_prev_in = s1_req_ff.ca1_level;
               end
               if (s1_req_ff.cb1_level != cb1_prev_ff) begin
                  if (pcr_ff[PCR_CB1_POS] == s1_req_ff.cb1_level) begin
                     ifr_in[FLAG_CB1] = 1'b1;
                  end
                  cb1_prev_in = s1_req_ff.cb1_level;
               end
            end
            ACT_READ: begin
               rd_out = read_val;
               case (s1_req_ff.reg_index)
                  REG_ORB: begin
                     ifr_in[FLAG_CB1] = 1'b0;
                     ifr_in[FLAG_CB2] = 1'b0;
                  end
                  REG_ORA: begin
                     ifr_in[FLAG_CA1] = 1'b0;
                     ifr_in[FLAG_CA2] = 1'b0;
                  end
                  REG_T1CL: ifr_in[FLAG_T1] = 1'b0;
                  REG_T2CL: ifr_in[FLAG_T2] = 1'b0;
                  default: ;
               endcase
            end
            ACT_WRITE: begin
               case (s1_req_ff.reg_index)
                  REG_ORB: begin
                     out_b_in         = s1_req_ff.data;
                     ifr_in[FLAG_CB1] = 1'b0;
                     ifr_in[FLAG_CB2] = 1'b0;
                  end
                  REG_ORA: begin
                     out_a_in         = s1_req_ff.data;
                     ifr_in[FLAG_CA1] = 1'b0;
                     ifr_in[FLAG_CA2] = 1'b0;
                  end
                  REG_DDRB: dir_b_in = s1_req_ff.data;
                  REG_DDRA: dir_a_in = s1_req_ff.data;
                  REG_T1CL, REG_T1LL: begin
                     t1_reload_in = {t1_reload_ff[15:8], s1_req_ff.data};
                  end
                  REG_T1CH: begin
                     t1_reload_in    = {s1_req_ff.data, t1_reload_ff[7:0]};
                     t1_count_in     = {2'b00, s1_req_ff.data, t1_reload_ff[7:0]};
                     ifr_in[FLAG_T1] = 1'b0;
                     t1_fired_in     = 1'b0;
                  end
                  REG_T1LH: begin
                     t1_reload_in    = {s1_req_ff.data, t1_reload_ff[7:0]};
                     ifr_in[FLAG_T1] = 1'b0;
                  end
                  REG_T2CL: t2_low_in = s1_req_ff.data;
                  REG_T2CH: begin
                     t2_count_in     = {2'b00, s1_req_ff.data, t2_low_ff};
                     ifr_in[FLAG_T2] = 1'b0;
                     t2_fired_in     = 1'b0;
                  end
                  REG_SR:  sr_in  = s1_req_ff.data;
                  REG_ACR: acr_in = s1_req_ff.data;
                  REG_PCR: begin
                     pcr_in = s1_req_ff.data;
                     if (s1_req_ff.data[3:1] == CTL2_MANUAL_LOW) begin
                        ca2_in = 1'b0;
                     end else if (s1_req_ff.data[3:1] == CTL2_MANUAL_HIGH) begin
                        ca2_in = 1'b1;
                     end
                     if (s1_req_ff.data[7:5] == CTL2_MANUAL_LOW) begin
                        cb2_in = 1'b0;
                     end else if (s1_req_ff.data[7:5] == CTL2_MANUAL_HIGH) begin
                        cb2_in = 1'b1;
                     end
                  end
                  REG_IFR: ifr_in = ifr_ff & ~s1_req_ff.data[6:0];
                  REG_IER: begin
                     if (s1_req_ff.data[7]) begin
                        ier_in = ier_ff | s1_req_ff.data[6:0];
                     end else begin
                        ier_in = ier_ff & ~s1_req_ff.data[6:0];
                     end
                  end
                  default: out_a_in = s1_req_ff.data;
               endcase
               // Output bits follow ORx, input bits keep the driven level;
               // only a write to that port's own registers settles its pins
               if (s1_req_ff.reg_index inside {REG_ORA, REG_DDRA, REG_ORA_NH}) begin
                  pins_a_in = (out_a_in & dir_a_in) | (pins_a_ff & ~dir_a_in);
               end
               if (s1_req_ff.reg_index inside {REG_ORB, REG_DDRB}) begin
                  pins_b_in = (out_b_in & dir_b_in) | (pins_b_ff & ~dir_b_in);
               end
            end
            ACT_DRIVE_A: pins_a_in = s1_req_ff.data;
            ACT_DRIVE_B: pins_b_in = s1_req_ff.data;
            default: ;
         endcase
      end

      rsp_in.read_data   = rd_out;
      rsp_in.irq         = |(ifr_in & ier_in);
      rsp_in.port_a_pins = pins_a_in;
      rsp_in.port_b_pins = pins_b_in;
      rsp_in.ca2_out     = ca2_in;
      rsp_in.cb2_out     = cb2_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         t1_count_ff  <= '0;
         t1_reload_ff <= '0;
         t2_count_ff  <= '0;
         t2_low_ff    <= '0;
         t1_fired_ff  <= 1'b0;
         t2_fired_ff  <= 1'b0;
         ca1_prev_ff  <= 1'b0;
         cb1_prev_ff  <= 1'b0;
         ca2_ff       <= 1'b0;
         cb2_ff       <= 1'b0;
         dir_a_ff     <= '0;
         dir_b_ff     <= '0;
         out_a_ff     <= '0;
         out_b_ff     <= '0;
         pins_a_ff    <= '1;
         pins_b_ff    <= '1;
         ifr_ff       <= '0;
         ier_ff       <= '0;
         acr_ff       <= '0;
         pcr_ff       <= '0;
         sr_ff        <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         t1_count_ff  <= t1_count_in;
         t1_reload_ff <= t1_reload_in;
         t2_count_ff  <= t2_count_in;
         t2_low_ff    <= t2_low_in;
         t1_fired_ff  <= t1_fired_in;
         t2_fired_ff  <= t2_fired_in;
         ca1_prev_ff  <= ca1_prev_in;
         cb1_prev_ff  <= cb1_prev_in;
         ca2_ff       <= ca2_in;
         cb2_ff       <= cb2_in;
         dir_a_ff     <= dir_a_in;
         dir_b_ff     <= dir_b_in;
         out_a_ff     <= out_a_in;
         out_b_ff     <= out_b_in;
         pins_a_ff    <= pins_a_in;
         pins_b_ff    <= pins_b_in;
         ifr_ff       <= ifr_in;
         ier_ff       <= ier_in;
         acr_ff       <= acr_in;
         pcr_ff       <= pcr_in;
         sr_ff        <= sr_in;
      end
   end

   // Payload registers: request loads on accept, result on execute; both hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_req_ff <= req_payload;
      end
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- sv/via_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the versatile interface adapter, bound to the top.
// Depends on via_pkg and versatile_interface_adapter_defines.svh.
`include "versatile_interface_adapter_defines.svh"

module via_checker
   import via_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   // Results never survive reset
   `VIA_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

   // Hold a stalled result
   `VIA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                    rsp_valid && $stable(rsp_payload))

   // Backpressure only comes from a stalled, full result register
   `VIA_ASSERT_IMPL(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // Every accepted transaction shows a valid result once past the request and result registers
   `VIA_ASSERT_NEXT(a_rsp_follows, clock, reset, req_valid && !req_stall,
                    ##1 rsp_valid)

endmodule

bind versatile_interface_adapter via_checker u_via_checker (.*);
